// File: design/hpi_pkg.sv
// ----------------------------------------------------------------------------
// hpi_pkg
// Types, constants and formats shared by the HSV pixel illumination block.
// ----------------------------------------------------------------------------
`default_nettype none

package hpi_pkg;

  // intensity and register format
  localparam int IFB   = 14;
  localparam int IW    = IFB + 1;
  localparam int CW    = 15;
  localparam int ONE_I = 1 << IFB;

  // hsv format
  localparam int HF  = 24;
  localparam int HW  = HF + 1;
  localparam int HUW = HF + 3;
  localparam logic [HW-1:0] HSV_ONE = HW'(1) << HF;
  localparam int TSH = HF - IFB;

  // value: floor(mx * 2^24 / 255) = mx * 65793 + (mx == 255)
  localparam logic [16:0] V_MUL = 17'd65793;

  // blend product widths
  localparam int MW  = IW + HW;
  localparam int SW  = MW + 1;

  // long division
  localparam int NUMW = 11;
  localparam int DIVW = NUMW + HF;
  localparam int NLANE = 2;

  // byte conversion: floor(x * 255999 / (1000 * 2^24))
  localparam logic [17:0] BYTE_MUL = 18'd255999;
  localparam int          YW       = 18;
  localparam int          RSH      = 40;
  localparam logic [30:0] RECIP    = 31'd1099511628;
  localparam int          ZW       = YW + 31;

  // queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    CFG_BRIGHT_SAT = 3'd0,
    CFG_BRIGHT_VAL = 3'd1,
    CFG_DARK_SAT   = 3'd2,
    CFG_DARK_VAL   = 3'd3
  } cfg_reg_e;

  localparam logic [CW-1:0] RST_BRIGHT_SAT = CW'(1638);
  localparam logic [CW-1:0] RST_BRIGHT_VAL = CW'(16384);
  localparam logic [CW-1:0] RST_DARK_SAT   = CW'(16384);
  localparam logic [CW-1:0] RST_DARK_VAL   = CW'(4915);

  typedef struct packed {
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic signed [15:0] intensity;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic [CW-1:0] bright_saturation;
    logic [CW-1:0] bright_value;
    logic [CW-1:0] dark_saturation;
    logic [CW-1:0] dark_value;
  } cfg_t;

  // classified word between front and back
  typedef struct packed {
    logic            pass;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      mx;
    logic [7:0]      diff;
    logic [NUMW-1:0] hnum;
    logic [IW-1:0]   w;
    logic [IW-1:0]   di;
    logic [CW-1:0]   tsat;
    logic [CW-1:0]   tval;
  } cls_t;

endpackage

`default_nettype wire

// File: design/hpi_front.sv
// ----------------------------------------------------------------------------
// hpi_front
// Classifies a pixel: max, min, hue numerator, blend weights and targets.
// ----------------------------------------------------------------------------
`default_nettype none

module hpi_front (
  input  hpi_pkg::pix_in_t pixel,
  input  hpi_pkg::cfg_t    cfg,
  output hpi_pkg::cls_t    cls
);

  logic [7:0]           r, g, b, mx, mn;
  logic signed [11:0]   ds, t_s;
  logic signed [15:0]   iv;
  logic [hpi_pkg::IW-1:0] w;
  logic                 pos;

  always_comb begin
    r = pixel.red_in;
    g = pixel.green_in;
    b = pixel.blue_in;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    ds = $signed({4'b0, mx - mn});
    if (r == mx) begin
      t_s = $signed({4'b0, g}) - $signed({4'b0, b});
      if (t_s < 0) t_s = t_s + ds * 12'sd6;
    end else if (g == mx) begin
      t_s = ds * 12'sd2 + $signed({4'b0, b}) - $signed({4'b0, r});
    end else begin
      t_s = ds * 12'sd4 + $signed({4'b0, r}) - $signed({4'b0, g});
    end

    iv = pixel.intensity;
    if (iv > 16'(hpi_pkg::ONE_I)) iv = 16'(hpi_pkg::ONE_I);
    if (iv < -16'(hpi_pkg::ONE_I)) iv = -16'(hpi_pkg::ONE_I);
    pos = !iv[15];
    w = pos ? hpi_pkg::IW'(iv) : hpi_pkg::IW'(-iv);

    cls.pass  = (pixel.intensity == 16'sd0);
    cls.red   = r;
    cls.green = g;
    cls.blue  = b;
    cls.mx    = mx;
    cls.diff  = mx - mn;
    cls.hnum  = t_s[hpi_pkg::NUMW-1:0];
    cls.w     = w;
    cls.di    = hpi_pkg::IW'(hpi_pkg::ONE_I) - w;
    cls.tsat  = pos ? cfg.bright_saturation : cfg.dark_saturation;
    cls.tval  = pos ? cfg.bright_value : cfg.dark_value;
  end

endmodule

`default_nettype wire

// File: design/hpi_queue.sv
// ----------------------------------------------------------------------------
// hpi_queue
// Short word queue between the classifying front and the back pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module hpi_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hpi_pkg::cls_t wdata,
  input  logic          pop,
  output hpi_pkg::cls_t rdata,
  output logic          full,
  output logic          empty
);

  hpi_pkg::cls_t            mem [hpi_pkg::QDEPTH];
  logic [hpi_pkg::QAW-1:0]  wptr, rptr;
  logic [hpi_pkg::QAW:0]    count;

  assign full  = (count == (hpi_pkg::QAW+1)'(hpi_pkg::QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (hpi_pkg::QAW+1)'(push) - (hpi_pkg::QAW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count: assert property (@(posedge clk) disable iff (rst)
      !$past(rst) |-> count == $past(count) + (hpi_pkg::QAW+1)'($past(push))
                              - (hpi_pkg::QAW+1)'($past(pop)))
    else $error("queue count mismatch");
`endif

endmodule

`default_nettype wire

// File: design/hpi_back.sv
// ----------------------------------------------------------------------------
// hpi_back
// Pipelined long division to HSV, blend, HSV to RGB and byte conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module hpi_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              avail,
  input  hpi_pkg::cls_t     head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output hpi_pkg::pix_out_t result
);

  localparam int D  = hpi_pkg::DIVW;
  localparam int NL = hpi_pkg::NLANE;
  localparam int HW = hpi_pkg::HW;

  logic en;

  // division pipeline
  logic                dv   [D+1];
  hpi_pkg::cls_t       side [D+1];
  logic [7:0]          rem  [D+1][NL];
  logic [D-1:0]        dq   [D+1][NL];
  logic [7:0]          den  [D+1][NL];
  logic [HW-1:0]       vr;

  logic [8:0]          sh   [D][NL];
  logic                ge   [D][NL];

  assign en  = !(result_valid && result_stall);
  assign pop = en && avail;

  always_comb begin
    for (int k = 0; k < D; k++) begin
      for (int l = 0; l < NL; l++) begin
        sh[k][l] = {rem[k][l], dq[k][l][D-1]};
        ge[k][l] = sh[k][l] >= {1'b0, den[k][l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= D; k++) dv[k] <= 1'b0;
    end else if (en) begin
      dv[0] <= pop;
      for (int k = 0; k < D; k++) dv[k+1] <= dv[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= head;
      for (int l = 0; l < NL; l++) rem[0][l] <= '0;
      dq[0][0]  <= {3'b0, head.diff, hpi_pkg::HF'(0)};
      dq[0][1]  <= {head.hnum, hpi_pkg::HF'(0)};
      den[0][0] <= head.mx;
      den[0][1] <= head.diff;
      for (int k = 0; k < D; k++) begin
        side[k+1] <= side[k];
        for (int l = 0; l < NL; l++) begin
          rem[k+1][l] <= ge[k][l] ? 8'(sh[k][l] - {1'b0, den[k][l]}) : sh[k][l][7:0];
          dq[k+1][l]  <= {dq[k][l][D-2:0], ge[k][l]};
          den[k+1][l] <= den[k][l];
        end
      end
      // value by reciprocal product, aligned with the last division stage
      vr <= HW'(side[D-1].mx) * HW'(hpi_pkg::V_MUL) + HW'(side[D-1].mx == 8'hff);
    end
  end

  // blend, hsv to rgb, byte conversion
  logic [5:0] vb;
  hpi_pkg::cls_t c1, c2, c3, c4, c5;

  logic [HW-1:0]             v0, s0;
  logic [hpi_pkg::HUW-1:0]   hue0, hue1, hue2;
  logic [hpi_pkg::MW-1:0]    m_ds, m_dv;
  logic [hpi_pkg::IW+hpi_pkg::CW-1:0] m_wt, m_wv;
  logic                      sz1;
  logic [hpi_pkg::SW-1:0]    sum_s, sum_v;
  logic [hpi_pkg::SW-hpi_pkg::IFB-1:0] bs, bv;
  logic [HW-1:0]             s2, v2, s3, v3, v4;
  logic [HW-1:0]             p3, sf3, sg3, p4, q4, t4;
  logic [2*HW-1:0]           mp, msf, msg, mq, mt;
  logic                      sz4;
  logic [2:0]                sec3, sec4;
  logic [HW-1:0]             rr, gg, bb;
  logic [HW+hpi_pkg::YW-1:0] yr, yg, yb;
  logic [hpi_pkg::YW-1:0]    y5 [3];
  logic [hpi_pkg::ZW-1:0]    z  [3];

  always_comb begin
    v0   = vr;
    s0   = (side[D].mx == 8'd0) ? '0 : dq[D][0][HW-1:0];
    hue0 = dq[D][1][hpi_pkg::HUW-1:0];
  end

  always_comb begin
    sum_s = {1'b0, m_ds} + hpi_pkg::SW'({m_wt, hpi_pkg::TSH'(0)});
    sum_v = {1'b0, m_dv} + hpi_pkg::SW'({m_wv, hpi_pkg::TSH'(0)});
    bs = sum_s[hpi_pkg::SW-1:hpi_pkg::IFB];
    bv = sum_v[hpi_pkg::SW-1:hpi_pkg::IFB];
  end

  always_comb begin
    mp  = v2 * (hpi_pkg::HSV_ONE - s2);
    msf = s2 * {1'b0, hue2[hpi_pkg::HF-1:0]};
    msg = s2 * (hpi_pkg::HSV_ONE - {1'b0, hue2[hpi_pkg::HF-1:0]});
    mq  = v3 * (hpi_pkg::HSV_ONE - sf3);
    mt  = v3 * (hpi_pkg::HSV_ONE - sg3);
  end

  always_comb begin
    if (sz4) begin
      rr = v4; gg = v4; bb = v4;
    end else begin
      unique case (sec4)
        3'd0: begin rr = v4; gg = t4; bb = p4; end
        3'd1: begin rr = q4; gg = v4; bb = p4; end
        3'd2: begin rr = p4; gg = v4; bb = t4; end
        3'd3: begin rr = p4; gg = q4; bb = v4; end
        3'd4: begin rr = t4; gg = p4; bb = v4; end
        default: begin rr = v4; gg = p4; bb = q4; end
      endcase
    end
    yr = rr * hpi_pkg::BYTE_MUL;
    yg = gg * hpi_pkg::BYTE_MUL;
    yb = bb * hpi_pkg::BYTE_MUL;
    for (int i = 0; i < 3; i++) z[i] = y5[i] * hpi_pkg::RECIP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (en) begin
      vb <= {vb[4:0], dv[D]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: blend products
      c1   <= side[D];
      hue1 <= hue0;
      sz1  <= (s0 == '0);
      m_ds <= side[D].di * s0;
      m_dv <= side[D].di * v0;
      m_wt <= side[D].w * side[D].tsat;
      m_wv <= side[D].w * side[D].tval;
      // stage 2: sum and clamp
      c2   <= c1;
      hue2 <= hue1;
      s2   <= sz1 ? '0 :
              ((bs > (hpi_pkg::SW-hpi_pkg::IFB)'(hpi_pkg::HSV_ONE)) ?
               hpi_pkg::HSV_ONE : HW'(bs));
      v2   <= (bv > (hpi_pkg::SW-hpi_pkg::IFB)'(hpi_pkg::HSV_ONE)) ?
              hpi_pkg::HSV_ONE : HW'(bv);
      // stage 3: p and s*f terms
      c3   <= c2;
      s3   <= s2;
      v3   <= v2;
      sec3 <= hue2[hpi_pkg::HUW-1:hpi_pkg::HF];
      p3   <= mp[hpi_pkg::HF+HW-1:hpi_pkg::HF];
      sf3  <= msf[hpi_pkg::HF+HW-1:hpi_pkg::HF];
      sg3  <= msg[hpi_pkg::HF+HW-1:hpi_pkg::HF];
      // stage 4: q and t
      c4   <= c3;
      v4   <= v3;
      sz4  <= (s3 == '0);
      sec4 <= sec3;
      p4   <= p3;
      q4   <= mq[hpi_pkg::HF+HW-1:hpi_pkg::HF];
      t4   <= mt[hpi_pkg::HF+HW-1:hpi_pkg::HF];
      // stage 5: sector select, scale
      c5    <= c4;
      y5[0] <= yr[hpi_pkg::HF+hpi_pkg::YW-1:hpi_pkg::HF];
      y5[1] <= yg[hpi_pkg::HF+hpi_pkg::YW-1:hpi_pkg::HF];
      y5[2] <= yb[hpi_pkg::HF+hpi_pkg::YW-1:hpi_pkg::HF];
      // stage 6: output word
      if (c5.pass) begin
        result.red_out   <= c5.red;
        result.green_out <= c5.green;
        result.blue_out  <= c5.blue;
      end else begin
        result.red_out   <= z[0][hpi_pkg::RSH+7:hpi_pkg::RSH];
        result.green_out <= z[1][hpi_pkg::RSH+7:hpi_pkg::RSH];
        result.blue_out  <= z[2][hpi_pkg::RSH+7:hpi_pkg::RSH];
      end
    end
  end

  assign result_valid = vb[5];

endmodule

`default_nettype wire

// File: design/hsv_pixel_illumination.sv
// ----------------------------------------------------------------------------
// hsv_pixel_illumination
// Shades RGB pixels in HSV space by a signed illumination intensity.
// ----------------------------------------------------------------------------
// Takes one pixel word per cycle unless pixel_stall is high (queue full) and
// returns one word per pixel, in order. The depth is set by the long division
// to hue and saturation, one quotient bit per stage over 35 stages (value comes
// from a reciprocal product beside the last stage), followed by six blend and
// conversion stages. A four word queue sits between the classifying front and
// the pipeline; the pipeline advances whenever its output register is empty or
// being taken. Configuration writes are always ready and take effect for pixels
// accepted afterward.
`default_nettype none

module hsv_pixel_illumination (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  hpi_pkg::pix_in_t      pixel,
  output logic                  result_valid,
  input  logic                  result_stall,
  output hpi_pkg::pix_out_t     result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [hpi_pkg::CW-1:0] cfg_data
);

  hpi_pkg::cfg_t cfg;
  hpi_pkg::cls_t cls, head;
  logic          push, pop, full, empty;

  assign cfg_ready   = 1'b1;
  assign pixel_stall = full;
  assign push        = pixel_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bright_saturation <= hpi_pkg::RST_BRIGHT_SAT;
      cfg.bright_value      <= hpi_pkg::RST_BRIGHT_VAL;
      cfg.dark_saturation   <= hpi_pkg::RST_DARK_SAT;
      cfg.dark_value        <= hpi_pkg::RST_DARK_VAL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (hpi_pkg::cfg_reg_e'(cfg_index))
        hpi_pkg::CFG_BRIGHT_SAT: cfg.bright_saturation <= cfg_data;
        hpi_pkg::CFG_BRIGHT_VAL: cfg.bright_value      <= cfg_data;
        hpi_pkg::CFG_DARK_SAT:   cfg.dark_saturation   <= cfg_data;
        hpi_pkg::CFG_DARK_VAL:   cfg.dark_value        <= cfg_data;
        default: ;
      endcase
    end
  end

  hpi_front u_front (
    .pixel (pixel),
    .cfg   (cfg),
    .cls   (cls)
  );

  hpi_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .pop   (pop),
    .rdata (head),
    .full  (full),
    .empty (empty)
  );

  hpi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .avail        (!empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
